// ===== design/isu_pkg.sv =====
// Shared constants and helpers for the interval set union/subtract block.
`timescale 1ns / 1ps

package isu_pkg;

    // Default table depth and position width.
    localparam int DEF_MAX_SEGMENTS  = 16;
    localparam int DEF_POSITION_BITS = 32;

    // Widths of the stream payloads.
    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 96;
    localparam int OUT_USER_W = 2;

    // Adds a nonnegative length to a running total and saturates at all ones.
    function automatic logic [31:0] sat_add(input logic [31:0] tot, input logic [32:0] len);
        logic [33:0] sum;
        sum = {2'b00, tot} + {1'b0, len};
        if (sum[33:32] != 2'b00)
        begin
            return '1;
        end
        return sum[31:0];
    endfunction

endpackage

// ===== design/isu_mem.sv =====
// Single-port table memory with a registered read port.
`timescale 1ns / 1ps

module isu_mem #(
    parameter int DEPTH = 32,
    parameter int AW    = 5,
    parameter int DW    = 64
) (
    input  logic          clk,
    input  logic          we,
    input  logic          re,
    input  logic [AW-1:0] addr,
    input  logic [DW-1:0] wdata,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [0:DEPTH-1];
    logic [DW-1:0] rdata_reg;

    // One write or one read per cycle; the read data is registered.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/interval_set_union_subtract_core.sv =====
// Top level of the interval set union/subtract block.
`timescale 1ns / 1ps

// Keeps a sorted set of disjoint intervals in a two-bank table memory. A job
// (two endpoints on s_tdata, open/close on s_tuser) sweeps the stored
// intervals: each entry is read (ST_RD), classified (ST_CALC) and its zero
// to two resulting pieces are written into the other bank one at a time
// (ST_WR) before the next entry is read. The new table is taken only if it
// fits in MAX_SEGMENTS entries; otherwise the old set stays and every result
// carries the overflow flag. The set is then streamed out, one interval per
// transfer (read, wait for the data, hold for the sink), with tlast on the
// final one, or a single transfer flagged empty. No clearing pass is needed
// after reset. s_tready is high only between jobs.
module interval_set_union_subtract_core
#(
    parameter int MAX_SEGMENTS  = isu_pkg::DEF_MAX_SEGMENTS,
    parameter int POSITION_BITS = isu_pkg::DEF_POSITION_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [31:0] job_start, [63:32] job_end
    input  logic [isu_pkg::IN_DATA_W-1:0]    s_tdata,
    // [0] action
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [31:0] seg_start, [63:32] seg_end, [95:64] total_length
    output logic [isu_pkg::OUT_DATA_W-1:0]   m_tdata,
    // [0] set_empty, [1] overflow
    output logic [isu_pkg::OUT_USER_W-1:0]   m_tuser,
    output logic                             m_tlast
);

    import isu_pkg::*;

    localparam int PW    = (POSITION_BITS < 32) ? POSITION_BITS : 32;
    localparam int CW    = $clog2(MAX_SEGMENTS + 2);
    localparam int DEPTH = 2 * MAX_SEGMENTS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IW    = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_RD     = 8'b0000_0010,
        ST_CALC   = 8'b0000_0100,
        ST_WR     = 8'b0000_1000,
        ST_DECIDE = 8'b0001_0000,
        ST_ERD    = 8'b0010_0000,
        ST_EWAIT  = 8'b0100_0000,
        ST_EHOLD  = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    // Control state.
    logic          bank_reg, bank_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] n_reg, n_next;
    logic          open_reg, open_next;
    logic          placed_reg, placed_next;
    logic          p0v_reg, p0v_next;
    logic          p1v_reg, p1v_next;
    logic          ovf_reg, ovf_next;

    // Payload state.
    logic signed [PW-1:0] a_reg, a_next;
    logic signed [PW-1:0] b_reg, b_next;
    logic signed [PW-1:0] p0s_reg, p0s_next, p0e_reg, p0e_next;
    logic signed [PW-1:0] p1s_reg, p1s_next, p1e_reg, p1e_next;
    logic [31:0]          old_tot_reg, old_tot_next;
    logic [31:0]          new_tot_reg, new_tot_next;
    logic [31:0]          tot_reg, tot_next;
    logic signed [PW-1:0] os_reg, os_next, oe_reg, oe_next;
    logic                 oempty_reg, oempty_next;
    logic                 olast_reg, olast_next;

    // Memory port.
    logic            mem_we, mem_re;
    logic [AW-1:0]   mem_addr;
    logic [2*PW-1:0] mem_wdata, mem_rdata;
    logic            addr_bank;
    logic [IW-1:0]   addr_idx;

    logic signed [PW-1:0] in_p, in_q, rs, re_pos;
    logic [PW:0]          old_len, w_len;

    isu_mem #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .DW    (2 * PW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .re    (mem_re),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    assign in_p   = s_tdata[PW-1:0];
    assign in_q   = s_tdata[32+PW-1:32];
    assign rs     = mem_rdata[PW-1:0];
    assign re_pos = mem_rdata[2*PW-1:PW];

    // Bank select: entries of bank 1 sit above those of bank 0.
    assign mem_addr = addr_bank ? (AW'(MAX_SEGMENTS) + AW'(addr_idx)) : AW'(addr_idx);

    // Lengths are positive differences, one bit wider than a position.
    assign old_len = {re_pos[PW-1], re_pos} - {rs[PW-1], rs};
    assign w_len   = p0v_reg ? ({p0e_reg[PW-1], p0e_reg} - {p0s_reg[PW-1], p0s_reg})
                             : ({p1e_reg[PW-1], p1e_reg} - {p1s_reg[PW-1], p1s_reg});

    // Sweep and output sequencer.
    always_comb
    begin
        state_next   = state_reg;
        bank_next    = bank_reg;
        cnt_next     = cnt_reg;
        idx_next     = idx_reg;
        n_next       = n_reg;
        open_next    = open_reg;
        placed_next  = placed_reg;
        p0v_next     = p0v_reg;
        p1v_next     = p1v_reg;
        ovf_next     = ovf_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        p0s_next     = p0s_reg;
        p0e_next     = p0e_reg;
        p1s_next     = p1s_reg;
        p1e_next     = p1e_reg;
        old_tot_next = old_tot_reg;
        new_tot_next = new_tot_reg;
        tot_next     = tot_reg;
        os_next      = os_reg;
        oe_next      = oe_reg;
        oempty_next  = oempty_reg;
        olast_next   = olast_reg;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        mem_wdata    = {p0e_reg, p0s_reg};
        addr_bank    = bank_reg;
        addr_idx     = idx_reg[IW-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    a_next       = (in_p < in_q) ? in_p : in_q;
                    b_next       = (in_p < in_q) ? in_q : in_p;
                    open_next    = s_tuser;
                    placed_next  = 1'b0;
                    idx_next     = '0;
                    n_next       = '0;
                    old_tot_next = '0;
                    new_tot_next = '0;
                    state_next   = ST_RD;
                end
            end

            ST_RD:
            begin
                if (idx_reg != cnt_reg)
                begin
                    mem_re     = 1'b1;
                    state_next = ST_CALC;
                end
                else if (open_reg && !placed_reg && (b_reg > a_reg))
                begin
                    // The job interval lies beyond every stored one.
                    p0s_next    = a_reg;
                    p0e_next    = b_reg;
                    p0v_next    = 1'b1;
                    p1v_next    = 1'b0;
                    placed_next = 1'b1;
                    state_next  = ST_WR;
                end
                else
                begin
                    state_next = ST_DECIDE;
                end
            end

            ST_CALC:
            begin
                old_tot_next = sat_add(old_tot_reg, 33'(old_len));
                idx_next     = idx_reg + 1'b1;
                p0v_next     = 1'b0;
                p1v_next     = 1'b0;
                state_next   = ST_WR;
                if (open_reg)
                begin
                    if (re_pos < a_reg)
                    begin
                        p0s_next = rs;
                        p0e_next = re_pos;
                        p0v_next = 1'b1;
                    end
                    else if (rs > b_reg)
                    begin
                        if (!placed_reg && (b_reg > a_reg))
                        begin
                            p0s_next = a_reg;
                            p0e_next = b_reg;
                            p0v_next = 1'b1;
                            p1s_next = rs;
                            p1e_next = re_pos;
                            p1v_next = 1'b1;
                        end
                        else
                        begin
                            p0s_next = rs;
                            p0e_next = re_pos;
                            p0v_next = 1'b1;
                        end
                        placed_next = 1'b1;
                    end
                    else
                    begin
                        // Overlapping or touching: widen the job interval.
                        if (rs < a_reg)
                        begin
                            a_next = rs;
                        end
                        if (re_pos > b_reg)
                        begin
                            b_next = re_pos;
                        end
                    end
                end
                else
                begin
                    if ((a_reg == b_reg) || (re_pos <= a_reg) || (rs >= b_reg))
                    begin
                        p0s_next = rs;
                        p0e_next = re_pos;
                        p0v_next = 1'b1;
                    end
                    else
                    begin
                        p0s_next = rs;
                        p0e_next = a_reg;
                        p0v_next = (rs < a_reg);
                        p1s_next = b_reg;
                        p1e_next = re_pos;
                        p1v_next = (b_reg < re_pos);
                    end
                end
            end

            ST_WR:
            begin
                // Write one pending piece into the other bank per cycle; pieces beyond MAX_SEGMENTS are only counted.
                addr_bank = !bank_reg;
                addr_idx  = n_reg[IW-1:0];
                if (p0v_reg || p1v_reg)
                begin
                    mem_wdata    = p0v_reg ? {p0e_reg, p0s_reg} : {p1e_reg, p1s_reg};
                    mem_we       = (n_reg < CW'(MAX_SEGMENTS));
                    new_tot_next = sat_add(new_tot_reg, 33'(w_len));
                    if (n_reg <= CW'(MAX_SEGMENTS))
                    begin
                        n_next = n_reg + 1'b1;
                    end
                    if (p0v_reg)
                    begin
                        p0s_next = p1s_reg;
                        p0e_next = p1e_reg;
                        p0v_next = p1v_reg;
                    end
                    p1v_next = 1'b0;
                    if (p0v_reg)
                    begin
                        p1v_next = 1'b0;
                    end
                end
                else
                begin
                    state_next = ST_RD;
                end
            end

            ST_DECIDE:
            begin
                ovf_next = (n_reg > CW'(MAX_SEGMENTS));
                if (n_reg > CW'(MAX_SEGMENTS))
                begin
                    tot_next = old_tot_reg;
                end
                else
                begin
                    bank_next = !bank_reg;
                    cnt_next  = n_reg;
                    tot_next  = new_tot_reg;
                end
                idx_next   = '0;
                state_next = ST_ERD;
            end

            ST_ERD:
            begin
                if (cnt_reg == '0)
                begin
                    os_next     = '0;
                    oe_next     = '0;
                    oempty_next = 1'b1;
                    olast_next  = 1'b1;
                    state_next  = ST_EHOLD;
                end
                else
                begin
                    mem_re     = 1'b1;
                    state_next = ST_EWAIT;
                end
            end

            ST_EWAIT:
            begin
                os_next     = rs;
                oe_next     = re_pos;
                oempty_next = 1'b0;
                olast_next  = (idx_reg == cnt_reg - 1'b1);
                state_next  = ST_EHOLD;
            end

            ST_EHOLD:
            begin
                if (m_tready)
                begin
                    if (olast_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_ERD;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            bank_reg   <= 1'b0;
            cnt_reg    <= '0;
            idx_reg    <= '0;
            n_reg      <= '0;
            open_reg   <= 1'b0;
            placed_reg <= 1'b0;
            p0v_reg    <= 1'b0;
            p1v_reg    <= 1'b0;
            ovf_reg    <= 1'b0;
            olast_reg  <= 1'b0;
            oempty_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            bank_reg   <= bank_next;
            cnt_reg    <= cnt_next;
            idx_reg    <= idx_next;
            n_reg      <= n_next;
            open_reg   <= open_next;
            placed_reg <= placed_next;
            p0v_reg    <= p0v_next;
            p1v_reg    <= p1v_next;
            ovf_reg    <= ovf_next;
            olast_reg  <= olast_next;
            oempty_reg <= oempty_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        a_reg       <= a_next;
        b_reg       <= b_next;
        p0s_reg     <= p0s_next;
        p0e_reg     <= p0e_next;
        p1s_reg     <= p1s_next;
        p1e_reg     <= p1e_next;
        old_tot_reg <= old_tot_next;
        new_tot_reg <= new_tot_next;
        tot_reg     <= tot_next;
        os_reg      <= os_next;
        oe_reg      <= oe_next;
    end

    // Stream ports.
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_EHOLD);
    assign m_tdata  = {tot_reg, 32'(oe_reg), 32'(os_reg)};
    assign m_tuser  = {ovf_reg, oempty_reg};
    assign m_tlast  = olast_reg;

    // A stored interval always has positive length.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !oempty_reg) |-> (oe_reg > os_reg))
        else $error("emitted interval has no positive length");

    // An empty set is reported in one transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && oempty_reg) |-> (m_tlast && (cnt_reg == '0)))
        else $error("empty result is not a single last transfer");

    // The committed table never exceeds its capacity.
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(MAX_SEGMENTS))
        else $error("table count exceeds capacity");

endmodule

// ===== verif/interval_set_union_subtract_core_test.sv =====
// Testbench for the interval set union/subtract core with a self-checking set predictor.
`timescale 1ns / 1ps

module interval_set_union_subtract_core_test;
    import isu_pkg::*;

    localparam int  TABLE_DEPTH = DEF_MAX_SEGMENTS;
    localparam int  CYCLE_LIMIT = 2000000;
    localparam int  MAX_REPORTS = 10;
    localparam logic ACT_CLOSE  = 1'b0;
    localparam logic ACT_OPEN   = 1'b1;

    typedef struct packed {
        logic [31:0] seg_start;
        logic [31:0] seg_end;
        logic [31:0] total_length;
        logic        set_empty;
        logic        overflow;
        logic        last;
    } segment_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [OUT_USER_W-1:0] m_tuser;
    logic                  m_tlast;

    // Predicted contents of the interval table.
    longint          set_starts[TABLE_DEPTH];
    longint          set_ends[TABLE_DEPTH];
    int              set_count;
    segment_result_t pending_segments[$];

    int     mismatches;
    int     cycles;
    int     hold_off_cycles;
    int     stall_left;
    bit     sink_calm;
    bit     source_calm;

    interval_set_union_subtract_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Applies one job to the predicted set and queues the expected transfers.
    task automatic apply_job(input logic [31:0] p_raw, input logic [31:0] q_raw,
                             input logic act);
        longint          p;
        longint          q;
        longint          lo;
        longint          hi;
        longint          new_starts[TABLE_DEPTH + 2];
        longint          new_ends[TABLE_DEPTH + 2];
        int              n;
        bit              placed;
        bit              rejected;
        longint          total;
        segment_result_t r;
        p = longint'($signed(p_raw));
        q = longint'($signed(q_raw));
        lo = (p < q) ? p : q;
        hi = (p < q) ? q : p;
        n = 0;
        placed = 0;
        total = 0;
        if (act == ACT_OPEN)
        begin
            for (int i = 0; i < set_count; i++)
            begin
                if (set_ends[i] < lo)
                begin
                    new_starts[n] = set_starts[i];
                    new_ends[n] = set_ends[i];
                    n++;
                end
                else if (set_starts[i] > hi)
                begin
                    if (!placed)
                    begin
                        if (hi > lo)
                        begin
                            new_starts[n] = lo;
                            new_ends[n] = hi;
                            n++;
                        end
                        placed = 1;
                    end
                    new_starts[n] = set_starts[i];
                    new_ends[n] = set_ends[i];
                    n++;
                end
                else
                begin
                    if (set_starts[i] < lo)
                        lo = set_starts[i];
                    if (set_ends[i] > hi)
                        hi = set_ends[i];
                end
            end
            if (!placed && hi > lo)
            begin
                new_starts[n] = lo;
                new_ends[n] = hi;
                n++;
            end
        end
        else
        begin
            for (int i = 0; i < set_count; i++)
            begin
                if (lo == hi || set_ends[i] <= lo || set_starts[i] >= hi)
                begin
                    new_starts[n] = set_starts[i];
                    new_ends[n] = set_ends[i];
                    n++;
                end
                else
                begin
                    if (set_starts[i] < lo)
                    begin
                        new_starts[n] = set_starts[i];
                        new_ends[n] = lo;
                        n++;
                    end
                    if (hi < set_ends[i])
                    begin
                        new_starts[n] = hi;
                        new_ends[n] = set_ends[i];
                        n++;
                    end
                end
            end
        end

        // A job that does not fit leaves the set as it was.
        rejected = (n > TABLE_DEPTH);
        if (!rejected)
        begin
            for (int i = 0; i < n; i++)
            begin
                set_starts[i] = new_starts[i];
                set_ends[i] = new_ends[i];
            end
            set_count = n;
        end

        for (int i = 0; i < set_count; i++)
        begin
            total += set_ends[i] - set_starts[i];
            if (total > 64'hFFFF_FFFF)
                total = 64'hFFFF_FFFF;
        end

        if (set_count == 0)
        begin
            r = '0;
            r.set_empty = 1'b1;
            r.overflow = rejected;
            r.last = 1'b1;
            pending_segments = {pending_segments, r};
        end
        for (int i = 0; i < set_count; i++)
        begin
            r.seg_start = set_starts[i][31:0];
            r.seg_end = set_ends[i][31:0];
            r.total_length = total[31:0];
            r.set_empty = 1'b0;
            r.overflow = rejected;
            r.last = (i == set_count - 1);
            pending_segments = {pending_segments, r};
        end
    endtask

    // Mostly no gap or a short one, a few long ones, and calm stretches with none.
    function automatic int pick_gap(input bit calm);
        int roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 60)
            return 0;
        if (roll < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Offers one job and waits for its transfer.
    task automatic send_job(input logic [31:0] p_raw, input logic [31:0] q_raw,
                            input logic act);
        int gap;
        if ($urandom_range(0, 29) == 0)
            source_calm = !source_calm;
        gap = pick_gap(source_calm);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {q_raw, p_raw};
        s_tuser <= act;
        do
            @(posedge clk);
        while (!s_tready);
        apply_job(p_raw, q_raw, act);
    endtask

    // Sink readiness: random stalls plus a long hold-off on request.
    always @(posedge clk)
    begin
        if (hold_off_cycles > 0)
        begin
            m_tready <= 1'b0;
            hold_off_cycles <= hold_off_cycles - 1;
        end
        else if (stall_left > 0)
        begin
            m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            if ($urandom_range(0, 199) == 0)
                sink_calm <= !sink_calm;
            m_tready <= 1'b1;
            stall_left <= pick_gap(sink_calm);
        end
    end

    // Compares each output transfer with the oldest predicted segment.
    always @(posedge clk)
    begin
        segment_result_t want;
        segment_result_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.seg_start = m_tdata[31:0];
            got.seg_end = m_tdata[63:32];
            got.total_length = m_tdata[95:64];
            got.set_empty = m_tuser[0];
            got.overflow = m_tuser[1];
            got.last = m_tlast;
            if (pending_segments.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected transfer: start %0d end %0d total %0d",
                             $signed(got.seg_start), $signed(got.seg_end),
                             got.total_length);
            end
            else
            begin
                want = pending_segments.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("mismatch: want s=%0d e=%0d tot=%0d emp=%b ovf=%b last=%b, got s=%0d e=%0d tot=%0d emp=%b ovf=%b last=%b",
                                 $signed(want.seg_start), $signed(want.seg_end),
                                 want.total_length, want.set_empty, want.overflow,
                                 want.last, $signed(got.seg_start),
                                 $signed(got.seg_end), got.total_length,
                                 got.set_empty, got.overflow, got.last);
                end
            end
        end
    end

    // Extremes, ordering, zero-length jobs, edges, touching and a full table.
    task automatic test_directed();
        send_job(32'd0, 32'd0, ACT_CLOSE);
        send_job(32'd5, 32'd5, ACT_OPEN);
        send_job(32'h7FFF_FFFF, 32'h8000_0000, ACT_OPEN);
        send_job(32'h8000_0000, 32'h7FFF_FFFF, ACT_CLOSE);
        send_job(32'd20, 32'd10, ACT_OPEN);
        send_job(32'd20, 32'd30, ACT_OPEN);
        send_job(32'd15, 32'd15, ACT_OPEN);
        send_job(32'd40, 32'd40, ACT_OPEN);
        send_job(32'd18, 32'd18, ACT_CLOSE);
        send_job(32'd10, 32'd12, ACT_CLOSE);
        send_job(32'd25, 32'd30, ACT_CLOSE);
        send_job(32'd15, 32'd20, ACT_CLOSE);
        send_job(-32'sd100, 32'd100, ACT_CLOSE);
        // Seventeen disjoint pieces: the last one cannot fit.
        for (int i = 0; i < TABLE_DEPTH + 1; i++)
            send_job(32'(i * 10), 32'(i * 10 + 5), ACT_OPEN);
        send_job(32'd2, 32'd3, ACT_CLOSE);
        send_job(32'h8000_0000, 32'h7FFF_FFFF, ACT_CLOSE);
    endtask

    // Random jobs, mostly over a narrow window so that pieces interact.
    task automatic test_random(input int count);
        logic [31:0] p;
        logic [31:0] q;
        logic        act;
        int          roll;
        for (int k = 0; k < count; k++)
        begin
            roll = $urandom_range(0, 99);
            act = ($urandom_range(0, 99) < 55) ? ACT_OPEN : ACT_CLOSE;
            if (roll < 10)
            begin
                p = $urandom;
                q = $urandom;
            end
            else if (roll < 13)
            begin
                p = 32'h8000_0000;
                q = 32'h7FFF_FFFF;
                act = ACT_CLOSE;
            end
            else
            begin
                p = 32'($urandom_range(0, 400)) - 32'd200;
                q = p + 32'($urandom_range(0, 40));
                if ($urandom_range(0, 1))
                    {p, q} = {q, p};
            end
            send_job(p, q, act);
        end
    endtask

    // Sink held off for a long stretch while jobs keep coming.
    task automatic test_backpressure();
        hold_off_cycles = 400;
        for (int k = 0; k < 6; k++)
            send_job(32'(k * 7), 32'(k * 7 + 3), ACT_OPEN);
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        m_tready = 1'b0;
        set_count = 0;
        mismatches = 0;
        cycles = 0;
        hold_off_cycles = 0;
        stall_left = 0;
        sink_calm = 0;
        source_calm = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(122);
        test_backpressure();
        s_tvalid <= 1'b0;

        // Drain what is still predicted, then let the block settle.
        while (pending_segments.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);

        if (mismatches == 0 && pending_segments.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
